// File: src/dfq_pkg.sv
// Shared constants, operation and status codes, and control types for the dedup queue.
package dfq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int WIDTH_DEF   = 32;

    localparam int DATA_W      = 32;
    localparam int POS_W       = 4;
    localparam int CNT_W       = 5;
    localparam int MODE_W      = 2;
    localparam int STAT_W      = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_DUP   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd3;
    localparam logic [STAT_W-1:0] STAT_RANGE = 3'd4;

    typedef struct packed {
        logic capture;
        logic scan;
        logic read;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic in_enq;
        logic in_rw;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

// File: src/dedup_fifo_queue.sv
// FIFO queue that stores each value at most once: a request in mode 0 enqueues (dropped as a
// duplicate or when full), mode 1 dequeues the oldest entry and mode 2 peeks at a position
// from the head; each request yields one result with data, status and the entry count. One
// request is in work at a time. An enqueue scans the stored entries through the single read
// port of the entry memory, one per cycle, and stops early when a duplicate is found; dequeue
// and peek read one entry and a no-op reads none. The next request is taken while the previous
// result still waits on the output; a request that finishes before that result is taken holds
// in its last cycle until the output frees.
module dedup_fifo_queue #(
    parameter int DEPTH = dfq_pkg::DEPTH_DEF,
    parameter int WIDTH = dfq_pkg::WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // value[31:0], position[35:32], zeros above
    input  logic [dfq_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // mode[1:0]
    input  logic [dfq_pkg::MODE_W-1:0]      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // data[31:0], count[36:32], zeros above
    output logic [dfq_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // status[2:0]
    output logic [dfq_pkg::STAT_W-1:0]      o_m_axis_tuser
);

    dfq_pkg::t_cmd cmd;
    dfq_pkg::t_sts sts;

    dfq_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    dfq_dpath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

// File: src/dfq_ctrl.sv
// Controller state machine: sequences accept, duplicate scan, entry read and commit.
module dfq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  dfq_pkg::t_sts i_sts,
    output dfq_pkg::t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    if (i_sts.in_enq) begin
                        n_state = ST_SCAN;
                    end else if (i_sts.in_rw) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cmd.capture   = (r_state == ST_IDLE) && i_s_axis_tvalid;
    assign o_cmd.scan      = (r_state == ST_SCAN);
    assign o_cmd.read      = (r_state == ST_READ);
    assign o_cmd.commit    = (r_state == ST_DONE) && i_sts.out_free;

endmodule

// File: src/dfq_dpath.sv
// Datapath: entry memory, head and occupancy, duplicate scan and the output register.
module dfq_dpath #(
    parameter int DEPTH = dfq_pkg::DEPTH_DEF,
    parameter int WIDTH = dfq_pkg::WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [dfq_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    input  logic [dfq_pkg::MODE_W-1:0]          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [dfq_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic [dfq_pkg::STAT_W-1:0]          o_m_axis_tuser,
    input  dfq_pkg::t_cmd                       i_cmd,
    output dfq_pkg::t_sts                       o_sts
);

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    localparam int SW = OW + 1;
    localparam int PW = (OW > dfq_pkg::POS_W) ? OW : dfq_pkg::POS_W;
    localparam int DW = dfq_pkg::DATA_W;
    localparam int CW = dfq_pkg::CNT_W;
    localparam int PSW = dfq_pkg::POS_W;

    // entry memory, one write and one registered read per cycle
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    logic [dfq_pkg::MODE_W-1:0] r_mode;
    logic [WIDTH-1:0]           r_value;
    logic [PSW-1:0]             r_pos;
    logic [AW-1:0]              r_head;
    logic [OW-1:0]              r_occ;
    logic [OW-1:0]              r_idx;
    logic                       r_hit;
    logic                       r_rd_vld;
    logic                       r_out_vld;
    logic [DW-1:0]              r_out_data;
    logic [dfq_pkg::STAT_W-1:0] r_out_status;
    logic [CW-1:0]              r_out_count;

    logic                       rd_en;
    logic                       scan_rd;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic                       wr_en;
    logic [OW-1:0]              rd_off;
    logic                       peek_ok;
    logic [AW-1:0]              n_head;
    logic [OW-1:0]              n_occ;
    logic [DW-1:0]              n_data;
    logic [dfq_pkg::STAT_W-1:0] n_status;
    logic [DW-1:0]              rd_word;

    // (head + offset) wrapped into the buffer; offset is at most DEPTH, so one subtraction wraps it
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [OW-1:0] off);
        logic [SW-1:0] sum;
        begin
            sum = SW'(head) + SW'(off);
            if (sum >= SW'(DEPTH)) begin
                sum = sum - SW'(DEPTH);
            end
            return sum[AW-1:0];
        end
    endfunction

    assign peek_ok = PW'(r_pos) < PW'(r_occ);
    assign rd_off  = ((r_mode == dfq_pkg::MODE_PEEK) && peek_ok) ? OW'(r_pos) : '0;
    assign scan_rd = i_cmd.scan && (r_idx < r_occ);
    assign rd_en   = scan_rd || i_cmd.read;
    assign rd_addr = slot_of(r_head, i_cmd.scan ? r_idx : rd_off);
    assign wr_addr = slot_of(r_head, r_occ);
    assign rd_word = DW'($signed(r_rd_data));

    always_comb begin
        n_head   = r_head;
        n_occ    = r_occ;
        n_data   = '0;
        n_status = dfq_pkg::STAT_OK;
        wr_en    = 1'b0;
        case (r_mode)
            dfq_pkg::MODE_ENQ: begin
                if (r_hit) begin
                    n_status = dfq_pkg::STAT_DUP;
                end else if (r_occ == OW'(DEPTH)) begin
                    n_status = dfq_pkg::STAT_FULL;
                end else begin
                    wr_en = i_cmd.commit;
                    n_occ = r_occ + OW'(1);
                end
            end
            dfq_pkg::MODE_DEQ: begin
                if (r_occ == '0) begin
                    n_status = dfq_pkg::STAT_EMPTY;
                end else begin
                    n_data = rd_word;
                    n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
                    n_occ  = r_occ - OW'(1);
                end
            end
            dfq_pkg::MODE_PEEK: begin
                if (!peek_ok) begin
                    n_status = dfq_pkg::STAT_RANGE;
                end else begin
                    n_data = rd_word;
                end
            end
            default: begin
                n_status = dfq_pkg::STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_s_axis_tuser;
            r_value <= WIDTH'(i_s_axis_tdata[DW-1:0]);
            r_pos   <= i_s_axis_tdata[DW +: PSW];
        end
        if (i_cmd.commit) begin
            r_out_data   <= n_data;
            r_out_status <= n_status;
            r_out_count  <= CW'(n_occ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_occ     <= '0;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= scan_rd;
            if (i_cmd.capture) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else begin
                if (scan_rd) begin
                    r_idx <= r_idx + OW'(1);
                end
                if (r_rd_vld && (r_rd_data == r_value)) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_head    <= n_head;
                r_occ     <= n_occ;
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.in_enq    = (i_s_axis_tuser == dfq_pkg::MODE_ENQ);
    assign o_sts.in_rw     = (i_s_axis_tuser == dfq_pkg::MODE_DEQ) ||
                             (i_s_axis_tuser == dfq_pkg::MODE_PEEK);
    assign o_sts.scan_done = r_hit || ((r_idx == r_occ) && !r_rd_vld);
    assign o_sts.out_free  = !r_out_vld || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = dfq_pkg::OUT_TDATA_W'({r_out_count, r_out_data});
    assign o_m_axis_tuser  = r_out_status;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(DEPTH))
        else $error("occupancy above depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_idx <= r_occ))
        else $error("scan index past occupancy");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_vld || i_m_axis_tready))
        else $error("result committed over an untaken result");

    a_enq_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_mode == dfq_pkg::MODE_ENQ) && !r_hit && (r_occ != OW'(DEPTH)))
        |=> (r_occ == $past(r_occ) + OW'(1)))
        else $error("accepted enqueue did not grow the queue");

    a_deq_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_mode == dfq_pkg::MODE_DEQ) && (r_occ != '0))
        |=> (r_occ == $past(r_occ) - OW'(1)))
        else $error("dequeue did not shrink the queue");

endmodule
